// ----- rtl/core/lcd_timing_mode_controller_core_defines.svh -----
// Assertion macros for the LCD mode timing controller.
// Included by the top level; depends on nothing else.
`ifndef LCD_TIMING_MODE_CONTROLLER_CORE_DEFINES_SVH
`define LCD_TIMING_MODE_CONTROLLER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTMC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcd timing controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define LTMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcd timing controller check failed");

`endif

// ----- rtl/core/lcdtmc_pkg.sv -----
// Shared types and codes for the LCD mode timing controller.
// No dependencies.
package lcdtmc_pkg;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_HBLANK = 2'd0;
    localparam t_mode MODE_VBLANK = 2'd1;
    localparam t_mode MODE_OAM    = 2'd2;
    localparam t_mode MODE_DRAW   = 2'd3;

    // Register index, taken from paddr[2].
    localparam logic REG_LINE_COMPARE = 1'b0;
    localparam logic REG_COIN_ENABLE  = 1'b1;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

endpackage

// ----- rtl/core/lcd_timing_mode_controller_core.sv -----
// LCD mode timing controller: dot and line counters, mode, coincidence and strobes.
// A result is registered and presented in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is not stalled; the output register frees up as its result is taken.
// Reset (synchronous, active low) clears the counters, the configuration registers and the output valid.
// Depends on lcdtmc_pkg and lcd_timing_mode_controller_core_defines.svh.
`include "lcd_timing_mode_controller_core_defines.svh"

module lcd_timing_mode_controller_core #(
    parameter int DOTS_PER_LINE = 456,
    parameter int VISIBLE_LINES = 144,
    parameter int LAST_LINE     = 153,
    parameter int SCAN_DOTS     = 80,
    parameter int DRAW_DOTS     = 172
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_advance,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_line,
    output logic [1:0]                        o_mode,
    output logic                              o_coincidence,
    output logic                              o_status_request,
    output logic                              o_vblank_request,
    output logic                              o_scan_start,
    output logic                              o_draw_start,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcdtmc_pkg::ADDR_W-1:0]     paddr,
    input  logic [lcdtmc_pkg::DATA_W-1:0]     pwdata,
    output logic [lcdtmc_pkg::DATA_W-1:0]     prdata,
    output logic                              pready
);

    localparam logic [8:0] DOTS_END   = 9'(DOTS_PER_LINE);
    localparam logic [8:0] SCAN_END   = 9'(SCAN_DOTS);
    localparam logic [8:0] DRAW_FIRST = 9'(SCAN_DOTS + 1);
    localparam logic [8:0] DRAW_END   = 9'(SCAN_DOTS + DRAW_DOTS);
    localparam logic [7:0] VIS_LINES  = 8'(VISIBLE_LINES);
    localparam logic [8:0] LAST_W     = 9'(LAST_LINE);

    // Configuration registers
    logic [7:0] r_line_compare;
    logic       r_coin_enable;

    // Timing state
    logic [8:0] r_dot_count, n_dot_count;
    logic [7:0] r_line_count, n_line_count;
    logic       r_last_coin, n_last_coin;

    // Result register
    logic       r_out_valid;
    logic [7:0] r_line;
    lcdtmc_pkg::t_mode r_mode, n_mode;
    logic       r_coin, n_coin;
    logic       r_stat_req, n_stat_req;
    logic       r_vb_req, n_vb_req;
    logic       r_scan, n_scan;
    logic       r_draw, n_draw;

    logic       in_accept;
    logic       cfg_write;
    logic [8:0] dot_inc;
    logic [8:0] line_inc;
    logic       visible;

    function automatic lcdtmc_pkg::t_mode mode_of(input logic [8:0] dot,
                                                  input logic [7:0] ln);
        lcdtmc_pkg::t_mode m;
        if ({1'b0, ln} >= 9'(VISIBLE_LINES) && {1'b0, ln} <= LAST_W) begin
            m = lcdtmc_pkg::MODE_VBLANK;
        end else if (dot >= 9'd1 && dot <= SCAN_END) begin
            m = lcdtmc_pkg::MODE_OAM;
        end else if (dot > SCAN_END && dot <= DRAW_END) begin
            m = lcdtmc_pkg::MODE_DRAW;
        end else begin
            m = lcdtmc_pkg::MODE_HBLANK;
        end
        return m;
    endfunction

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    always_comb begin
        unique case (paddr[2])
            lcdtmc_pkg::REG_LINE_COMPARE: prdata = {24'd0, r_line_compare};
            lcdtmc_pkg::REG_COIN_ENABLE:  prdata = {31'd0, r_coin_enable};
            default:                      prdata = '0;
        endcase
    end

    assign dot_inc  = r_dot_count + 9'd1;
    assign line_inc = {1'b0, r_line_count} + 9'd1;
    assign visible  = r_line_count < VIS_LINES;

    always_comb begin
        n_dot_count  = r_dot_count;
        n_line_count = r_line_count;
        n_last_coin  = r_last_coin;
        n_stat_req   = 1'b0;
        n_vb_req     = 1'b0;
        n_scan       = 1'b0;
        n_draw       = 1'b0;
        if (i_advance) begin
            n_scan = (dot_inc == 9'd1) && visible;
            n_draw = (dot_inc == DRAW_FIRST) && visible;
            // A wrap of the 9-bit counter also ends the line.
            if (dot_inc >= DOTS_END || dot_inc == 9'd0) begin
                n_dot_count = 9'd0;
                if (line_inc > LAST_W || line_inc > 9'd255) begin
                    n_line_count = 8'd0;
                end else begin
                    n_line_count = line_inc[7:0];
                end
                n_vb_req = (n_line_count == VIS_LINES);
            end else begin
                n_dot_count = dot_inc;
            end
            n_mode      = mode_of(n_dot_count, n_line_count);
            n_coin      = (n_line_count == r_line_compare);
            n_stat_req  = n_coin && !r_last_coin && r_coin_enable;
            n_last_coin = n_coin;
        end else begin
            n_mode = mode_of(r_dot_count, r_line_count);
            n_coin = (r_line_count == r_line_compare);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_compare <= 8'd0;
            r_coin_enable  <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                lcdtmc_pkg::REG_LINE_COMPARE: r_line_compare <= pwdata[7:0];
                lcdtmc_pkg::REG_COIN_ENABLE:  r_coin_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_count  <= 9'd0;
            r_line_count <= 8'd0;
            r_last_coin  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_dot_count  <= n_dot_count;
                r_line_count <= n_line_count;
                r_last_coin  <= n_last_coin;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_line     <= n_line_count;
            r_mode     <= n_mode;
            r_coin     <= n_coin;
            r_stat_req <= n_stat_req;
            r_vb_req   <= n_vb_req;
            r_scan     <= n_scan;
            r_draw     <= n_draw;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_line           = r_line;
    assign o_mode           = r_mode;
    assign o_coincidence    = r_coin;
    assign o_status_request = r_stat_req;
    assign o_vblank_request = r_vb_req;
    assign o_scan_start     = r_scan;
    assign o_draw_start     = r_draw;

    `LTMC_ASSERT_SAME(a_dot_in_range, i_clk, i_rst_n, 1'b1, r_dot_count < DOTS_END)
    `LTMC_ASSERT_SAME(a_line_in_range, i_clk, i_rst_n, 1'b1, {1'b0, r_line_count} <= LAST_W)
    `LTMC_ASSERT_SAME(a_vblank_line, i_clk, i_rst_n, o_out_valid && o_vblank_request, o_line == VIS_LINES)
    `LTMC_ASSERT_NEXT(a_scan_mode, i_clk, i_rst_n, in_accept && n_scan, r_mode == lcdtmc_pkg::MODE_OAM)

endmodule

// ----- tb/tb_lcd_timing_mode_controller_core.sv -----
// Self-checking testbench for lcd_timing_mode_controller_core: dot items in, timing results out.
// Holds its own dot/line predictor and drives the APB register port; depends on lcdtmc_pkg.
module tb_lcd_timing_mode_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DOTS_PER_LINE = 456;
    localparam int VISIBLE_LINES = 144;
    localparam int LAST_LINE     = 153;
    localparam int SCAN_DOTS     = 80;
    localparam int DRAW_DOTS     = 172;

    localparam int CHUNKS        = 8;
    localparam int CHUNK_DOTS    = 118;
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [7:0]        line;
        lcdtmc_pkg::t_mode mode;
        logic              coincidence;
        logic              status_req;
        logic              vblank_req;
        logic              scan_start;
        logic              draw_start;
    } t_dot_result;

    typedef struct packed {
        logic        advance;
        logic        typed;
        t_dot_result want;
    } t_dot_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_advance = 1'b0;
    logic i_out_stall = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [lcdtmc_pkg::ADDR_W-1:0] paddr = '0;
    logic [lcdtmc_pkg::DATA_W-1:0] pwdata = '0;

    logic o_in_stall;
    logic o_out_valid;
    logic [7:0] o_line;
    logic [1:0] o_mode;
    logic o_coincidence;
    logic o_status_request;
    logic o_vblank_request;
    logic o_scan_start;
    logic o_draw_start;
    logic [lcdtmc_pkg::DATA_W-1:0] prdata;
    logic pready;

    // Predictor state and its copy of the registers.
    logic [8:0] dot_pos = '0;
    logic [7:0] line_pos = '0;
    logic       prev_coincidence = 1'b0;
    logic [7:0] compare_reg = '0;
    logic       coin_irq_en = 1'b0;

    t_dot_result expected_dots_q[$];
    int fail_count = 0;
    int dots_sent = 0;
    int holds_sent = 0;
    int settings_used = 0;
    int vblank_seen = 0;
    int status_seen = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    lcd_timing_mode_controller_core #(
        .DOTS_PER_LINE(DOTS_PER_LINE),
        .VISIBLE_LINES(VISIBLE_LINES),
        .LAST_LINE    (LAST_LINE),
        .SCAN_DOTS    (SCAN_DOTS),
        .DRAW_DOTS    (DRAW_DOTS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_advance       (i_advance),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line          (o_line),
        .o_mode          (o_mode),
        .o_coincidence   (o_coincidence),
        .o_status_request(o_status_request),
        .o_vblank_request(o_vblank_request),
        .o_scan_start    (o_scan_start),
        .o_draw_start    (o_draw_start),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic lcdtmc_pkg::t_mode mode_at(input int dot, input int ln);
        if (ln >= VISIBLE_LINES && ln <= LAST_LINE) return lcdtmc_pkg::MODE_VBLANK;
        if (dot >= 1 && dot <= SCAN_DOTS) return lcdtmc_pkg::MODE_OAM;
        if (dot > SCAN_DOTS && dot <= SCAN_DOTS + DRAW_DOTS) return lcdtmc_pkg::MODE_DRAW;
        return lcdtmc_pkg::MODE_HBLANK;
    endfunction

    // Advances the dot/line counters by one item when advance is set, and returns the timing it should report.
    function automatic t_dot_result next_dot_timing(input logic advance);
        t_dot_result r;
        int next_dot;
        int next_line;
        logic visible;
        r = '0;
        if (advance) begin
            next_dot = (int'(dot_pos) + 1) & 'h1FF;
            visible = line_pos < VISIBLE_LINES;
            r.scan_start = (next_dot == 1) && visible;
            r.draw_start = (next_dot == SCAN_DOTS + 1) && visible;
            if (next_dot >= DOTS_PER_LINE || next_dot == 0) begin
                next_line = int'(line_pos) + 1;
                if (next_line > LAST_LINE || next_line > 255) next_line = 0;
                line_pos = next_line[7:0];
                dot_pos = '0;
                r.vblank_req = (next_line == VISIBLE_LINES);
                r.mode = mode_at(0, line_pos);
            end else begin
                dot_pos = next_dot[8:0];
                r.mode = mode_at(next_dot, line_pos);
            end
            r.coincidence = (line_pos == compare_reg);
            r.status_req = r.coincidence && !prev_coincidence && coin_irq_en;
            prev_coincidence = r.coincidence;
        end else begin
            r.mode = mode_at(dot_pos, line_pos);
            r.coincidence = (line_pos == compare_reg);
        end
        r.line = line_pos;
        return r;
    endfunction

    function automatic t_dot_row dot_row(input logic advance, input logic typed,
                                         input int ln, input lcdtmc_pkg::t_mode md,
                                         input logic coin,
                                         input logic stat, input logic vb, input logic scan,
                                         input logic draw);
        t_dot_row row;
        row.advance = advance;
        row.typed = typed;
        row.want = '{ln[7:0], md, coin, stat, vb, scan, draw};
        return row;
    endfunction

    // Sends one dot item, with random gaps before it, and records what it should produce.
    task automatic send_dot(input logic advance, input logic typed, input t_dot_result want);
        t_dot_result predicted;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_advance <= advance;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = next_dot_timing(advance);
        expected_dots_q.push_back(typed ? want : predicted);
        dots_sent++;
        if (!advance) holds_sent++;
    endtask

    task automatic apb_access(input logic write, input logic addr_sel,
                              input logic [lcdtmc_pkg::DATA_W-1:0] wdata,
                              output logic [lcdtmc_pkg::DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= {addr_sel, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes both registers, reads each back, and updates the predictor's copy.
    task automatic load_timing_regs(input logic [7:0] compare, input logic irq_en);
        logic [lcdtmc_pkg::DATA_W-1:0] rdata;
        apb_access(1'b1, lcdtmc_pkg::REG_LINE_COMPARE,
                   lcdtmc_pkg::DATA_W'(compare), rdata);
        apb_access(1'b0, lcdtmc_pkg::REG_LINE_COMPARE, '0, rdata);
        if (rdata[7:0] !== compare) begin
            $error("line_compare readback: expected %0d, actual %0d", compare, rdata[7:0]);
            fail_count++;
        end
        apb_access(1'b1, lcdtmc_pkg::REG_COIN_ENABLE,
                   lcdtmc_pkg::DATA_W'(irq_en), rdata);
        apb_access(1'b0, lcdtmc_pkg::REG_COIN_ENABLE, '0, rdata);
        if (rdata[0] !== irq_en) begin
            $error("coincidence_irq_enable readback: expected %0d, actual %0d",
                   irq_en, rdata[0]);
            fail_count++;
        end
        compare_reg = compare;
        coin_irq_en = irq_en;
        settings_used++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_dots_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Result side: checks each taken result and stalls at random.
    always @(posedge i_clk) begin : take_result
        t_dot_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (expected_dots_q.size() == 0) begin
                    $error("result taken with no item outstanding");
                    fail_count++;
                end else begin
                    want = expected_dots_q.pop_front();
                    if (o_line !== want.line) begin
                        $error("line: expected %0d, actual %0d", want.line, o_line);
                        fail_count++;
                    end
                    if (o_mode !== want.mode) begin
                        $error("mode: expected %0d, actual %0d", want.mode, o_mode);
                        fail_count++;
                    end
                    if (o_coincidence !== want.coincidence) begin
                        $error("coincidence: expected %0d, actual %0d",
                               want.coincidence, o_coincidence);
                        fail_count++;
                    end
                    if (o_status_request !== want.status_req) begin
                        $error("status_request: expected %0d, actual %0d",
                               want.status_req, o_status_request);
                        fail_count++;
                    end
                    if (o_vblank_request !== want.vblank_req) begin
                        $error("vblank_request: expected %0d, actual %0d",
                               want.vblank_req, o_vblank_request);
                        fail_count++;
                    end
                    if (o_scan_start !== want.scan_start) begin
                        $error("scan_start: expected %0d, actual %0d",
                               want.scan_start, o_scan_start);
                        fail_count++;
                    end
                    if (o_draw_start !== want.draw_start) begin
                        $error("draw_start: expected %0d, actual %0d",
                               want.draw_start, o_draw_start);
                        fail_count++;
                    end
                end
                if (o_vblank_request === 1'b1) vblank_seen++;
                if (o_status_request === 1'b1) status_seen++;
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timed out with %0d results still outstanding.", expected_dots_q.size());
            $display("** lcd_timing_mode_controller_core: FAILED **");
            $finish;
        end
    end

    initial begin
        t_dot_row directed_rows[8];
        logic [7:0] compare;
        directed_rows[0] = dot_row(1'b0, 1'b1, 0, lcdtmc_pkg::MODE_HBLANK,
                                   1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        directed_rows[1] = dot_row(1'b1, 1'b1, 0, lcdtmc_pkg::MODE_OAM,
                                   1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
        directed_rows[2] = dot_row(1'b1, 1'b1, 0, lcdtmc_pkg::MODE_OAM,
                                   1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        directed_rows[3] = dot_row(1'b0, 1'b1, 0, lcdtmc_pkg::MODE_OAM,
                                   1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        directed_rows[4] = dot_row(1'b1, 1'b0, 0, lcdtmc_pkg::MODE_HBLANK,
                                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        directed_rows[5] = dot_row(1'b0, 1'b0, 0, lcdtmc_pkg::MODE_HBLANK,
                                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        directed_rows[6] = dot_row(1'b1, 1'b0, 0, lcdtmc_pkg::MODE_HBLANK,
                                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        directed_rows[7] = dot_row(1'b1, 1'b0, 0, lcdtmc_pkg::MODE_HBLANK,
                                   1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A compare of line 0 with the interrupt enabled makes the first advancing dot
        // raise the status request.
        load_timing_regs(8'd0, 1'b1);
        foreach (directed_rows[i])
            send_dot(directed_rows[i].advance, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        // Chunks of mostly advancing dots, each under a fresh register setting, carry the
        // counters across a line end: heavy output stalls, then heavy input gaps, then neither.
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            if (chunk < CHUNKS / 4) begin
                gap_pct = 8;
                stall_pct = 82;
            end else if (chunk < CHUNKS / 2) begin
                gap_pct = 82;
                stall_pct = 8;
            end else begin
                gap_pct = 0;
                stall_pct = 0;
            end
            case ($urandom_range(5))
                0: compare = 8'd0;
                1: compare = 8'd255;
                2: compare = 8'(LAST_LINE);
                3: compare = 8'(VISIBLE_LINES);
                4: compare = 8'((int'(line_pos) + 1) % (LAST_LINE + 1));
                default: compare = 8'($urandom_range(255));
            endcase
            if (chunk == 0) load_timing_regs(8'd255, 1'b0);
            else load_timing_regs(compare, 1'($urandom_range(1)));
            for (int n = 0; n < CHUNK_DOTS; n++)
                send_dot($urandom_range(15) != 0, 1'b0, '0);
            drain_results();
        end

        $display("Sent %0d dot items (%0d holds) under %0d register settings.",
                 dots_sent, holds_sent, settings_used);
        $display("Observed %0d vblank and %0d status requests.", vblank_seen, status_seen);
        if (fail_count == 0)
            $display("** lcd_timing_mode_controller_core: PASSED **");
        else
            $display("** lcd_timing_mode_controller_core: FAILED **");
        $finish;
    end

endmodule
